// ----- rtl/format_spec_tokenizer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Format spec tokenizer: assertion macros
// Shared macros for the concurrent checks in the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef FORMAT_SPEC_TOKENIZER_CORE_DEFINES_SVH
`define FORMAT_SPEC_TOKENIZER_CORE_DEFINES_SVH

// Check that is suspended while reset is asserted.
`define FST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that is also evaluated while reset is asserted.
`define FST_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fst_pkg.sv -----
// ----------------------------------------------------------------------------
// Format spec tokenizer package
// Beat types, phase and type codes and the conversion decode function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fst_pkg;

  localparam int MAX_STRING_LEN = 4096;
  localparam int POS_W          = $clog2(MAX_STRING_LEN);
  localparam int LEN_W          = POS_W + 1;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LEN - 1);
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  // Parse phases.
  localparam logic [3:0] PH_TEXT  = 4'd0;
  localparam logic [3:0] PH_FLAGS = 4'd1;
  localparam logic [3:0] PH_WIDTH = 4'd2;
  localparam logic [3:0] PH_WSTAR = 4'd3;
  localparam logic [3:0] PH_DOT   = 4'd4;
  localparam logic [3:0] PH_PREC  = 4'd5;
  localparam logic [3:0] PH_PSTAR = 4'd6;
  localparam logic [3:0] PH_LEN_L = 4'd7;
  localparam logic [3:0] PH_CONV  = 4'd8;

  // Length modifiers.
  localparam logic [2:0] LM_NONE = 3'd0;
  localparam logic [2:0] LM_L    = 3'd1;
  localparam logic [2:0] LM_LL   = 3'd2;
  localparam logic [2:0] LM_Z    = 3'd3;
  localparam logic [2:0] LM_J    = 3'd4;
  localparam logic [2:0] LM_T    = 3'd5;

  // Token kinds.
  localparam logic [1:0] KIND_WSTAR = 2'd0;
  localparam logic [1:0] KIND_PSTAR = 2'd1;
  localparam logic [1:0] KIND_CONV  = 2'd2;

  // Expected argument type codes.
  localparam logic [4:0] TY_NONE     = 5'd0;
  localparam logic [4:0] TY_ANYINT   = 5'd1;
  localparam logic [4:0] TY_INT      = 5'd2;
  localparam logic [4:0] TY_UINT     = 5'd3;
  localparam logic [4:0] TY_LONG     = 5'd4;
  localparam logic [4:0] TY_ULONG    = 5'd5;
  localparam logic [4:0] TY_LLONG    = 5'd6;
  localparam logic [4:0] TY_ULLONG   = 5'd7;
  localparam logic [4:0] TY_SSIZE    = 5'd8;
  localparam logic [4:0] TY_SIZE     = 5'd9;
  localparam logic [4:0] TY_INTMAX   = 5'd10;
  localparam logic [4:0] TY_UINTMAX  = 5'd11;
  localparam logic [4:0] TY_PTRDIFF  = 5'd12;
  localparam logic [4:0] TY_CHARPTR  = 5'd13;
  localparam logic [4:0] TY_WCHARPTR = 5'd14;
  localparam logic [4:0] TY_ANYPTR   = 5'd15;
  localparam logic [4:0] TY_OBJECT   = 5'd16;
  localparam logic [4:0] TY_TYPEOBJ  = 5'd17;
  localparam logic [4:0] TY_UNKNOWN  = 5'd18;

  // Characters of interest.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_L_LOW   = 8'h6C;
  localparam logic [7:0] CH_Z_LOW   = 8'h7A;
  localparam logic [7:0] CH_J_LOW   = 8'h6A;
  localparam logic [7:0] CH_T_LOW   = 8'h74;
  localparam logic [7:0] CH_C_LOW   = 8'h63;
  localparam logic [7:0] CH_D_LOW   = 8'h64;
  localparam logic [7:0] CH_I_LOW   = 8'h69;
  localparam logic [7:0] CH_U_LOW   = 8'h75;
  localparam logic [7:0] CH_X_LOW   = 8'h78;
  localparam logic [7:0] CH_X_UP    = 8'h58;
  localparam logic [7:0] CH_O_LOW   = 8'h6F;
  localparam logic [7:0] CH_S_LOW   = 8'h73;
  localparam logic [7:0] CH_P_LOW   = 8'h70;
  localparam logic [7:0] CH_R_UP    = 8'h52;
  localparam logic [7:0] CH_S_UP    = 8'h53;
  localparam logic [7:0] CH_A_UP    = 8'h41;
  localparam logic [7:0] CH_U_UP    = 8'h55;
  localparam logic [7:0] CH_T_UP    = 8'h54;
  localparam logic [7:0] CH_N_UP    = 8'h4E;
  localparam logic [7:0] CH_V_UP    = 8'h56;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       token_kind;
    logic [7:0]       conversion_char;
    logic [POS_W-1:0] spec_start;
    logic [LEN_W-1:0] spec_length;
    logic [1:0]       arg_count;
    logic [4:0]       first_expected;
    logic [4:0]       second_expected;
    logic             from_last_byte;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] arg_count;
    logic [4:0] first_expected;
    logic [4:0] second_expected;
  } conv_info_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [4:0] int_code(input logic [2:0] lm, input logic sgn);
    logic [4:0] code;
    case (lm)
      LM_L:    code = sgn ? TY_LONG   : TY_ULONG;
      LM_LL:   code = sgn ? TY_LLONG  : TY_ULLONG;
      LM_Z:    code = sgn ? TY_SSIZE  : TY_SIZE;
      LM_J:    code = sgn ? TY_INTMAX : TY_UINTMAX;
      LM_T:    code = TY_PTRDIFF;
      default: code = sgn ? TY_INT    : TY_UINT;
    endcase
    return code;
  endfunction

  function automatic conv_info_t conv_decode(input logic [7:0] c, input logic [2:0] lm);
    conv_info_t info;
    logic [4:0] str_ty;
    str_ty = (lm == LM_L) ? TY_WCHARPTR : TY_CHARPTR;
    info.arg_count       = 2'd1;
    info.first_expected  = TY_UNKNOWN;
    info.second_expected = TY_NONE;
    case (c)
      CH_PERCENT: begin
        info.arg_count      = 2'd0;
        info.first_expected = TY_NONE;
      end
      CH_C_LOW:                    info.first_expected = TY_ANYINT;
      CH_D_LOW, CH_I_LOW:          info.first_expected = int_code(lm, 1'b1);
      CH_U_LOW, CH_X_LOW, CH_X_UP,
      CH_O_LOW:                    info.first_expected = int_code(lm, 1'b0);
      CH_S_LOW:                    info.first_expected = str_ty;
      CH_P_LOW:                    info.first_expected = TY_ANYPTR;
      CH_R_UP, CH_S_UP, CH_A_UP,
      CH_U_UP, CH_T_UP:            info.first_expected = TY_OBJECT;
      CH_N_UP:                     info.first_expected = TY_TYPEOBJ;
      CH_V_UP: begin
        info.arg_count       = 2'd2;
        info.first_expected  = TY_OBJECT;
        info.second_expected = str_ty;
      end
      default: ;
    endcase
    return info;
  endfunction

endpackage

// ----- rtl/format_spec_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// Format spec tokenizer core
// Streams a format string byte by byte and emits one token per star or
// conversion character of each printf-style spec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "format_spec_tokenizer_core_defines.svh"

// The block takes one format byte per cycle unless a token is held back. An
// accepted input beat is first captured in an input register; the phase
// machine then decides it and any token lands in the output register. The
// phase machine's update for every byte is what sets the sustained rate;
// bytes that raise no token are taken even while a token waits to be read,
// and only a byte that raises a token waits while a full output register
// is stalled.
// A string ends with the byte flagged end_of_string, after which the parser
// is back in text with its offset counter at zero. Offsets saturate at
// MAX_STRING_LEN-1.
module format_spec_tokenizer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fst_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fst_pkg::out_beat_t   out_data
);

  logic                          in_valid_r;
  fst_pkg::in_beat_t             in_r;
  logic                          out_valid_r;
  fst_pkg::out_beat_t            out_r;

  logic [3:0]                    phase_r, phase_nxt;
  logic [2:0]                    lm_r, lm_nxt;
  logic [fst_pkg::POS_W-1:0]     open_r, open_nxt;
  logic [fst_pkg::POS_W-1:0]     pos_r, pos_nxt;

  logic                          emit_star;
  logic [1:0]                    star_kind;
  logic                          do_loc;
  logic                          do_conv;
  logic                          res_valid;
  logic                          adv;
  logic                          step;
  fst_pkg::conv_info_t           info;
  fst_pkg::out_beat_t            res;
  logic [7:0]                    c;

  assign c = in_r.char_byte;

  always_comb begin
    phase_nxt = phase_r;
    lm_nxt    = lm_r;
    open_nxt  = open_r;
    emit_star = 1'b0;
    star_kind = fst_pkg::KIND_WSTAR;
    do_loc    = 1'b0;
    do_conv   = 1'b0;

    case (phase_r)
      fst_pkg::PH_FLAGS: begin
        if (c == fst_pkg::CH_MINUS || c == fst_pkg::CH_HASH || c == fst_pkg::CH_ZERO) begin
          phase_nxt = fst_pkg::PH_FLAGS;
        end else if (c == fst_pkg::CH_STAR) begin
          emit_star = 1'b1;
          star_kind = fst_pkg::KIND_WSTAR;
          phase_nxt = fst_pkg::PH_WSTAR;
        end else if (fst_pkg::is_digit(c)) begin
          phase_nxt = fst_pkg::PH_WIDTH;
        end else if (c == fst_pkg::CH_DOT) begin
          phase_nxt = fst_pkg::PH_DOT;
        end else begin
          do_loc = 1'b1;
        end
      end
      fst_pkg::PH_WIDTH: begin
        if (fst_pkg::is_digit(c)) begin
          phase_nxt = fst_pkg::PH_WIDTH;
        end else if (c == fst_pkg::CH_DOT) begin
          phase_nxt = fst_pkg::PH_DOT;
        end else begin
          do_loc = 1'b1;
        end
      end
      fst_pkg::PH_WSTAR: begin
        if (c == fst_pkg::CH_DOT) begin
          phase_nxt = fst_pkg::PH_DOT;
        end else begin
          do_loc = 1'b1;
        end
      end
      fst_pkg::PH_DOT: begin
        if (c == fst_pkg::CH_STAR) begin
          emit_star = 1'b1;
          star_kind = fst_pkg::KIND_PSTAR;
          phase_nxt = fst_pkg::PH_PSTAR;
        end else if (fst_pkg::is_digit(c)) begin
          phase_nxt = fst_pkg::PH_PREC;
        end else begin
          do_loc = 1'b1;
        end
      end
      fst_pkg::PH_PREC: begin
        if (!fst_pkg::is_digit(c)) begin
          do_loc = 1'b1;
        end
      end
      fst_pkg::PH_PSTAR: begin
        do_loc = 1'b1;
      end
      fst_pkg::PH_LEN_L: begin
        if (c == fst_pkg::CH_L_LOW) begin
          lm_nxt    = fst_pkg::LM_LL;
          phase_nxt = fst_pkg::PH_CONV;
        end else begin
          do_conv = 1'b1;
        end
      end
      fst_pkg::PH_CONV: begin
        do_conv = 1'b1;
      end
      default: begin
        // Text, and any phase code that cannot be reached.
        phase_nxt = fst_pkg::PH_TEXT;
        if (c == fst_pkg::CH_PERCENT) begin
          open_nxt  = pos_r;
          lm_nxt    = fst_pkg::LM_NONE;
          phase_nxt = fst_pkg::PH_FLAGS;
        end
      end
    endcase

    // A byte that may be either a length modifier or the conversion itself.
    if (do_loc) begin
      case (c)
        fst_pkg::CH_L_LOW: begin
          lm_nxt    = fst_pkg::LM_L;
          phase_nxt = fst_pkg::PH_LEN_L;
        end
        fst_pkg::CH_Z_LOW: begin
          lm_nxt    = fst_pkg::LM_Z;
          phase_nxt = fst_pkg::PH_CONV;
        end
        fst_pkg::CH_J_LOW: begin
          lm_nxt    = fst_pkg::LM_J;
          phase_nxt = fst_pkg::PH_CONV;
        end
        fst_pkg::CH_T_LOW: begin
          lm_nxt    = fst_pkg::LM_T;
          phase_nxt = fst_pkg::PH_CONV;
        end
        default: do_conv = 1'b1;
      endcase
    end

    if (do_conv) begin
      phase_nxt = fst_pkg::PH_TEXT;
    end

    pos_nxt = (pos_r < fst_pkg::POS_MAX) ? pos_r + fst_pkg::POS_ONE : pos_r;

    if (in_r.end_of_string) begin
      phase_nxt = fst_pkg::PH_TEXT;
      lm_nxt    = fst_pkg::LM_NONE;
      open_nxt  = '0;
      pos_nxt   = '0;
    end
  end

  // Token assembly. The modifier seen here is the one in force before this
  // byte, which is what the conversion is decoded against.
  always_comb begin
    info                = fst_pkg::conv_decode(c, lm_r);
    res.spec_start      = open_r;
    res.from_last_byte  = in_r.end_of_string;
    if (do_conv) begin
      res.token_kind      = fst_pkg::KIND_CONV;
      res.conversion_char = c;
      res.spec_length     = {1'b0, pos_r} - {1'b0, open_r} + fst_pkg::LEN_ONE;
      res.arg_count       = info.arg_count;
      res.first_expected  = info.first_expected;
      res.second_expected = info.second_expected;
    end else begin
      res.token_kind      = star_kind;
      res.conversion_char = '0;
      res.spec_length     = '0;
      res.arg_count       = 2'd1;
      res.first_expected  = fst_pkg::TY_INT;
      res.second_expected = fst_pkg::TY_NONE;
    end
  end

  assign res_valid = emit_star | do_conv;
  assign adv       = !res_valid || !out_valid_r || !out_stall;
  assign step      = in_valid_r && adv;
  assign in_stall  = in_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fst_pkg::PH_TEXT;
      lm_r    <= fst_pkg::LM_NONE;
      open_r  <= '0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      lm_r    <= lm_nxt;
      open_r  <= open_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  `FST_ASSERT_RST(a_reset_state,
    !rst_n |=> (phase_r == fst_pkg::PH_TEXT) && (pos_r == '0) && !out_valid_r,
    "parser not in text phase after reset")
  `FST_ASSERT(a_last_byte_clears,
    step && in_r.end_of_string |=> (phase_r == fst_pkg::PH_TEXT) && (pos_r == '0),
    "parser state not cleared after the final byte")
  `FST_ASSERT(a_held_input,
    in_valid_r && !adv |=> in_valid_r && $stable(in_r) && $stable(phase_r),
    "held input beat or phase changed while waiting for the output")
  `FST_ASSERT(a_star_len_zero,
    out_valid_r && (out_r.token_kind != fst_pkg::KIND_CONV) |->
      (out_r.spec_length == '0) && (out_r.arg_count == 2'd1),
    "star token with a nonzero length or wrong argument count")

endmodule

// ----- test/format_spec_tokenizer_checker.sv -----
// ----------------------------------------------------------------------------
// Format spec tokenizer checker
// Watches both channels of the tokenizer, predicts the token that each
// accepted format byte raises and compares every token beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module format_spec_tokenizer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  fst_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  fst_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending_tokens
);

  // Predicted parser state.
  logic [3:0]                phase;
  logic [2:0]                len_mod;
  logic [fst_pkg::POS_W-1:0] open_at;
  logic [fst_pkg::POS_W-1:0] byte_pos;

  fst_pkg::out_beat_t token_q[$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  task automatic add_token(input fst_pkg::out_beat_t t);
    token_q.insert(token_q.size(), t);
  endtask

  function automatic logic is_decimal(input logic [7:0] c);
    return c >= fst_pkg::CH_ZERO && c <= fst_pkg::CH_NINE;
  endfunction

  function automatic logic [4:0] int_type(input logic [2:0] lm, input logic is_signed);
    case (lm)
      fst_pkg::LM_L:  return is_signed ? fst_pkg::TY_LONG : fst_pkg::TY_ULONG;
      fst_pkg::LM_LL: return is_signed ? fst_pkg::TY_LLONG : fst_pkg::TY_ULLONG;
      fst_pkg::LM_Z:  return is_signed ? fst_pkg::TY_SSIZE : fst_pkg::TY_SIZE;
      fst_pkg::LM_J:  return is_signed ? fst_pkg::TY_INTMAX : fst_pkg::TY_UINTMAX;
      fst_pkg::LM_T:  return fst_pkg::TY_PTRDIFF;
      default:        return is_signed ? fst_pkg::TY_INT : fst_pkg::TY_UINT;
    endcase
  endfunction

  function automatic fst_pkg::out_beat_t star_token(input logic [1:0] kind,
                                                    input logic last);
    fst_pkg::out_beat_t t;
    t.token_kind      = kind;
    t.conversion_char = 8'd0;
    t.spec_start      = open_at;
    t.spec_length     = '0;
    t.arg_count       = 2'd1;
    t.first_expected  = fst_pkg::TY_INT;
    t.second_expected = fst_pkg::TY_NONE;
    t.from_last_byte  = last;
    return t;
  endfunction

  function automatic fst_pkg::out_beat_t conversion_token(
      input logic [7:0]                c,
      input logic [fst_pkg::POS_W-1:0] pos,
      input logic                      last);
    fst_pkg::out_beat_t t;
    logic [4:0]         text_ptr;
    text_ptr          = (len_mod == fst_pkg::LM_L) ? fst_pkg::TY_WCHARPTR
                                                   : fst_pkg::TY_CHARPTR;
    t.token_kind      = fst_pkg::KIND_CONV;
    t.conversion_char = c;
    t.spec_start      = open_at;
    // Once the offset has saturated the length can shrink down to one.
    t.spec_length     = {1'b0, pos} - {1'b0, open_at} + fst_pkg::LEN_ONE;
    t.arg_count       = 2'd1;
    t.first_expected  = fst_pkg::TY_UNKNOWN;
    t.second_expected = fst_pkg::TY_NONE;
    t.from_last_byte  = last;
    case (c)
      fst_pkg::CH_PERCENT: begin
        t.arg_count      = 2'd0;
        t.first_expected = fst_pkg::TY_NONE;
      end
      fst_pkg::CH_C_LOW: t.first_expected = fst_pkg::TY_ANYINT;
      fst_pkg::CH_D_LOW, fst_pkg::CH_I_LOW:
        t.first_expected = int_type(len_mod, 1'b1);
      fst_pkg::CH_U_LOW, fst_pkg::CH_X_LOW, fst_pkg::CH_X_UP, fst_pkg::CH_O_LOW:
        t.first_expected = int_type(len_mod, 1'b0);
      fst_pkg::CH_S_LOW: t.first_expected = text_ptr;
      fst_pkg::CH_P_LOW: t.first_expected = fst_pkg::TY_ANYPTR;
      fst_pkg::CH_R_UP, fst_pkg::CH_S_UP, fst_pkg::CH_A_UP, fst_pkg::CH_U_UP,
      fst_pkg::CH_T_UP: t.first_expected = fst_pkg::TY_OBJECT;
      fst_pkg::CH_N_UP: t.first_expected = fst_pkg::TY_TYPEOBJ;
      fst_pkg::CH_V_UP: begin
        t.arg_count       = 2'd2;
        t.first_expected  = fst_pkg::TY_OBJECT;
        t.second_expected = text_ptr;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic clear_state();
    phase    = fst_pkg::PH_TEXT;
    len_mod  = fst_pkg::LM_NONE;
    open_at  = '0;
    byte_pos = '0;
  endtask

  // A byte that is neither a flag, width nor precision part: either a length
  // modifier or the conversion character that closes the spec.
  task automatic modifier_or_conversion(input logic [7:0] c,
                                        input logic [fst_pkg::POS_W-1:0] pos,
                                        input logic last);
    case (c)
      fst_pkg::CH_L_LOW: begin
        len_mod = fst_pkg::LM_L;
        phase   = fst_pkg::PH_LEN_L;
      end
      fst_pkg::CH_Z_LOW: begin
        len_mod = fst_pkg::LM_Z;
        phase   = fst_pkg::PH_CONV;
      end
      fst_pkg::CH_J_LOW: begin
        len_mod = fst_pkg::LM_J;
        phase   = fst_pkg::PH_CONV;
      end
      fst_pkg::CH_T_LOW: begin
        len_mod = fst_pkg::LM_T;
        phase   = fst_pkg::PH_CONV;
      end
      default: begin
        add_token(conversion_token(c, pos, last));
        phase = fst_pkg::PH_TEXT;
      end
    endcase
  endtask

  task automatic tokenize(input fst_pkg::in_beat_t beat);
    logic [7:0]                c;
    logic                      last;
    logic [fst_pkg::POS_W-1:0] pos;
    c    = beat.char_byte;
    last = beat.end_of_string;
    pos  = byte_pos;
    case (phase)
      fst_pkg::PH_FLAGS: begin
        if (c == fst_pkg::CH_MINUS || c == fst_pkg::CH_HASH || c == fst_pkg::CH_ZERO) begin
        end else if (c == fst_pkg::CH_STAR) begin
          add_token(star_token(fst_pkg::KIND_WSTAR, last));
          phase = fst_pkg::PH_WSTAR;
        end else if (is_decimal(c)) begin
          phase = fst_pkg::PH_WIDTH;
        end else if (c == fst_pkg::CH_DOT) begin
          phase = fst_pkg::PH_DOT;
        end else begin
          modifier_or_conversion(c, pos, last);
        end
      end
      fst_pkg::PH_WIDTH: begin
        if (is_decimal(c)) begin
        end else if (c == fst_pkg::CH_DOT) begin
          phase = fst_pkg::PH_DOT;
        end else begin
          modifier_or_conversion(c, pos, last);
        end
      end
      // Digits after a width star are not a width: they close the spec.
      fst_pkg::PH_WSTAR: begin
        if (c == fst_pkg::CH_DOT) phase = fst_pkg::PH_DOT;
        else modifier_or_conversion(c, pos, last);
      end
      fst_pkg::PH_DOT: begin
        if (c == fst_pkg::CH_STAR) begin
          add_token(star_token(fst_pkg::KIND_PSTAR, last));
          phase = fst_pkg::PH_PSTAR;
        end else if (is_decimal(c)) begin
          phase = fst_pkg::PH_PREC;
        end else begin
          modifier_or_conversion(c, pos, last);
        end
      end
      fst_pkg::PH_PREC: begin
        if (!is_decimal(c)) modifier_or_conversion(c, pos, last);
      end
      fst_pkg::PH_PSTAR: modifier_or_conversion(c, pos, last);
      fst_pkg::PH_LEN_L: begin
        if (c == fst_pkg::CH_L_LOW) begin
          len_mod = fst_pkg::LM_LL;
          phase   = fst_pkg::PH_CONV;
        end else begin
          add_token(conversion_token(c, pos, last));
          phase = fst_pkg::PH_TEXT;
        end
      end
      fst_pkg::PH_CONV: begin
        add_token(conversion_token(c, pos, last));
        phase = fst_pkg::PH_TEXT;
      end
      default: begin
        phase = fst_pkg::PH_TEXT;
        if (c == fst_pkg::CH_PERCENT) begin
          open_at = pos;
          len_mod = fst_pkg::LM_NONE;
          phase   = fst_pkg::PH_FLAGS;
        end
      end
    endcase
    if (byte_pos < fst_pkg::POS_MAX) byte_pos = byte_pos + fst_pkg::POS_ONE;
    // A cut-short spec is simply dropped when the string ends.
    if (last) clear_state();
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    fst_pkg::out_beat_t want;
    if (!rst_n) begin
      clear_state();
      token_q.delete();
    end else begin
      // A token leaves only after its byte has passed the input and output
      // registers, so the output side is settled before this edge's input beat is predicted.
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("token beat with none expected: kind %0d, char 0x%0h, start %0d",
                 out_data.token_kind, out_data.conversion_char, out_data.spec_start);
          mismatches++;
        end else begin
          want = token_q.pop_front();
          compare_field("token_kind", want.token_kind, out_data.token_kind);
          compare_field("conversion_char", want.conversion_char, out_data.conversion_char);
          compare_field("spec_start", want.spec_start, out_data.spec_start);
          compare_field("spec_length", want.spec_length, out_data.spec_length);
          compare_field("arg_count", want.arg_count, out_data.arg_count);
          compare_field("first_expected", want.first_expected, out_data.first_expected);
          compare_field("second_expected", want.second_expected, out_data.second_expected);
          compare_field("from_last_byte", want.from_last_byte, out_data.from_last_byte);
        end
      end
      if (in_valid && !in_stall) tokenize(in_data);
    end
    pending_tokens <= token_q.size();
  end

endmodule

// ----- test/tb_format_spec_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// Format spec tokenizer testbench
// Feeds directed and random format strings through the tokenizer under
// several sender and receiver idling patterns, including a long receiver
// hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_format_spec_tokenizer_core;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 360;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  fst_pkg::in_beat_t  in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fst_pkg::out_beat_t out_data;

  int         fail_count;
  int         pending_tokens;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  bit         hold_request = 1'b0;
  int         items_sent   = 0;
  int         quiet_cycles = 0;
  logic [7:0] fmt_q[$];

  always #5 clk = ~clk;

  format_spec_tokenizer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  format_spec_tokenizer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    fmt_q.insert(fmt_q.size(), b);
  endtask

  task automatic send_beat(input logic [7:0] c, input logic last);
    fst_pkg::in_beat_t beat;
    beat.char_byte     = c;
    beat.end_of_string = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sends the string up to last_idx, which carries the end-of-string flag.
  task automatic send_string(input int last_idx);
    for (int i = 0; i <= last_idx; i++) send_beat(fmt_q[i], i == last_idx);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens != 0);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == fst_pkg::CH_PERCENT);
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'(fst_pkg::CH_ZERO + $urandom_range(9));
  endfunction

  function automatic logic [7:0] known_conversion(input int idx);
    case (idx)
      0:       return fst_pkg::CH_PERCENT;
      1:       return fst_pkg::CH_C_LOW;
      2:       return fst_pkg::CH_D_LOW;
      3:       return fst_pkg::CH_I_LOW;
      4:       return fst_pkg::CH_U_LOW;
      5:       return fst_pkg::CH_X_LOW;
      6:       return fst_pkg::CH_X_UP;
      7:       return fst_pkg::CH_O_LOW;
      8:       return fst_pkg::CH_S_LOW;
      9:       return fst_pkg::CH_P_LOW;
      10:      return fst_pkg::CH_R_UP;
      11:      return fst_pkg::CH_S_UP;
      12:      return fst_pkg::CH_A_UP;
      13:      return fst_pkg::CH_U_UP;
      14:      return fst_pkg::CH_T_UP;
      15:      return fst_pkg::CH_N_UP;
      default: return fst_pkg::CH_V_UP;
    endcase
  endfunction

  task automatic append_literal(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic append_text(input int n);
    repeat (n) add_byte(text_byte());
  endtask

  task automatic append_spec();
    add_byte(fst_pkg::CH_PERCENT);
    repeat ($urandom_range(3)) begin
      case ($urandom_range(2))
        0:       add_byte(fst_pkg::CH_MINUS);
        1:       add_byte(fst_pkg::CH_HASH);
        default: add_byte(fst_pkg::CH_ZERO);
      endcase
    end
    case ($urandom_range(2))
      1:       repeat ($urandom_range(1, 3)) add_byte(digit_byte());
      2:       add_byte(fst_pkg::CH_STAR);
      default: ;
    endcase
    case ($urandom_range(3))
      1: begin
        add_byte(fst_pkg::CH_DOT);
        repeat ($urandom_range(1, 3)) add_byte(digit_byte());
      end
      2: begin
        add_byte(fst_pkg::CH_DOT);
        add_byte(fst_pkg::CH_STAR);
      end
      3:       add_byte(fst_pkg::CH_DOT);
      default: ;
    endcase
    case ($urandom_range(5))
      1: add_byte(fst_pkg::CH_L_LOW);
      2: begin
        add_byte(fst_pkg::CH_L_LOW);
        add_byte(fst_pkg::CH_L_LOW);
      end
      3:       add_byte(fst_pkg::CH_Z_LOW);
      4:       add_byte(fst_pkg::CH_J_LOW);
      5:       add_byte(fst_pkg::CH_T_LOW);
      default: ;
    endcase
    if ($urandom_range(99) < 85) add_byte(known_conversion($urandom_range(16)));
    else add_byte(8'($urandom_range(255)));
  endtask

  task automatic send_literal(input string s);
    fmt_q.delete();
    append_literal(s);
    send_string(fmt_q.size() - 1);
  endtask

  // Mostly well-formed strings with random content; the rest is raw noise,
  // and a few strings are cut short at a random byte.
  task automatic random_string();
    int last_idx;
    fmt_q.delete();
    if ($urandom_range(99) < 80) begin
      repeat ($urandom_range(1, 4)) begin
        append_text($urandom_range(3));
        append_spec();
      end
      if ($urandom_range(1)) append_text($urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
    end
    last_idx = fmt_q.size() - 1;
    if ($urandom_range(99) < 10) last_idx = $urandom_range(fmt_q.size() - 1);
    send_string(last_idx);
  endtask

  initial begin
    int target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: all flags with both stars, digit width and precision,
    // digits after a width star, a spec cut short after the dot, a star on
    // the final byte and a wide V conversion.
    send_literal("%-#0*.*lld");
    send_literal("%5.3zu");
    send_literal("%*5");
    send_literal("%.");
    send_literal("%*");
    send_literal("%lV");
    wait_drained();

    // Long receiver hold-off against a token-heavy string fills the block.
    fmt_q.delete();
    repeat (40) append_literal("%d");
    hold_request = 1'b1;
    send_string(fmt_q.size() - 1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 76;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 76;
        end
        default: begin
          idle_pct  = 15;
          stall_pct = 15;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_string();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- format_spec_tokenizer_core.f -----
+incdir+rtl
rtl/fst_pkg.sv
rtl/format_spec_tokenizer_core.sv
test/format_spec_tokenizer_checker.sv
test/tb_format_spec_tokenizer_core.sv
